FILE: src/ms_pkg.sv
// shared types and constants of the merge sorter
`timescale 1ns / 1ps
`default_nettype none

package ms_pkg;

    // width of one element
    localparam int VALUE_W = 32;

    // one input transaction
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_item_t;

    // one result transaction
    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      final_res;
        logic                      overflow;
    } out_item_t;

endpackage

`default_nettype wire

FILE: src/ms_stream_if.sv
// valid/ready stream channel with a typed payload
`timescale 1ns / 1ps
`default_nettype none

interface ms_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

`default_nettype wire

FILE: src/merge_sorter.sv
// merge_sorter: loads a set, sorts it with a bottom-up merge over two memories, streams it out
// load: one cycle per input transaction; the input is held off while a set is sorted or emitted
// sort: ceil(log2(n)) merge passes; per element and pass a read state, then a compare/write state
// emit: per element a memory read, then hand-off to the output register, held while it cannot take it
// reset clears control state only; both element memories are not cleared and need no pass
`timescale 1ns / 1ps
`default_nettype none

module merge_sorter #(
    parameter int MAX_LEN = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    ms_stream_if.sink   in_chan,
    ms_stream_if.source out_chan
);

    localparam int VW = ms_pkg::VALUE_W;
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SW = $clog2(MAX_LEN + 1) + 1;
    localparam logic [SW-1:0] MAX_N = SW'(MAX_LEN);
    localparam logic [SW-1:0] ONE   = SW'(1);
    localparam logic [SW-1:0] ZERO  = SW'(0);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_WR,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    state_t          state_reg;
    logic [SW-1:0]   cnt_reg;
    logic            drop_reg;
    logic [SW-1:0]   width_reg;
    logic [SW-1:0]   lo_reg;
    logic [SW-1:0]   mid_reg;
    logic [SW-1:0]   hi_reg;
    logic [SW-1:0]   i_reg;
    logic [SW-1:0]   j_reg;
    logic [SW-1:0]   k_reg;
    logic [SW-1:0]   e_reg;
    logic            src_reg;

    // element store and merge scratch
    logic [VW-1:0]   mem_a [MAX_LEN];
    logic [VW-1:0]   mem_b [MAX_LEN];
    logic [VW-1:0]   a_q0;
    logic [VW-1:0]   a_q1;
    logic [VW-1:0]   b_q0;
    logic [VW-1:0]   b_q1;

    ms_stream_if #(.payload_t(ms_pkg::out_item_t)) emit_chan ();

    logic            in_fire;
    logic            has_room;
    logic [SW-1:0]   cnt_after;
    logic [VW-1:0]   rd_left;
    logic [VW-1:0]   rd_right;
    logic            take_left;
    logic [VW-1:0]   merge_val;
    logic [SW-1:0]   k_inc;
    logic            run_end;
    logic [SW-1:0]   w2;
    logic [SW-1:0]   lo_step;
    logic            pass_end;
    logic            sort_done;
    logic [SW-1:0]   setup_lo;
    logic [SW-1:0]   setup_w;
    logic [SW-1:0]   setup_n;
    logic [SW-1:0]   setup_mid;
    logic [SW-1:0]   setup_hi;
    logic [SW-1:0]   mid_raw;
    logic [SW-1:0]   hi_raw;
    logic            emit_final;
    logic            a_we;
    logic            b_we;
    logic [AW-1:0]   wr_addr;
    logic [VW-1:0]   wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr0;
    logic [AW-1:0]   rd_addr1;

    // input side
    assign in_chan.ready = (state_reg == ST_LOAD);
    assign in_fire       = in_chan.valid && in_chan.ready;
    assign has_room      = (cnt_reg < MAX_N);
    assign cnt_after     = has_room ? (cnt_reg + ONE) : cnt_reg;

    // merge compare, ties go to the left run
    assign rd_left   = src_reg ? b_q0 : a_q0;
    assign rd_right  = src_reg ? b_q1 : a_q1;
    assign take_left = (i_reg < mid_reg)
                    && ((j_reg >= hi_reg) || ($signed(rd_left) <= $signed(rd_right)));
    assign merge_val = take_left ? rd_left : rd_right;

    // run and pass bookkeeping
    assign k_inc     = k_reg + ONE;
    assign run_end   = (k_inc == hi_reg);
    assign w2        = width_reg + width_reg;
    assign lo_step   = lo_reg + w2;
    assign pass_end  = (lo_step >= cnt_reg);
    assign sort_done = (w2 >= cnt_reg);

    // bounds of the next run to merge
    always_comb
    begin
        if (state_reg == ST_LOAD)
        begin
            setup_lo = ZERO;
            setup_w  = ONE;
            setup_n  = cnt_after;
        end
        else
        begin
            setup_lo = pass_end ? ZERO : lo_step;
            setup_w  = pass_end ? w2 : width_reg;
            setup_n  = cnt_reg;
        end
        mid_raw   = setup_lo + setup_w;
        hi_raw    = mid_raw + setup_w;
        setup_mid = (mid_raw > setup_n) ? setup_n : mid_raw;
        setup_hi  = (hi_raw > setup_n) ? setup_n : hi_raw;
    end

    // memory port control
    assign a_we     = (in_fire && has_room) || ((state_reg == ST_SORT_WR) && src_reg);
    assign b_we     = (state_reg == ST_SORT_WR) && !src_reg;
    assign wr_addr  = (state_reg == ST_LOAD) ? cnt_reg[AW-1:0] : k_reg[AW-1:0];
    assign wr_data  = (state_reg == ST_LOAD) ? in_chan.data.value : merge_val;
    assign rd_en    = (state_reg == ST_SORT_RD) || (state_reg == ST_EMIT_RD);
    assign rd_addr0 = (state_reg == ST_EMIT_RD) ? e_reg[AW-1:0] : i_reg[AW-1:0];
    assign rd_addr1 = j_reg[AW-1:0];

    // memories: one write port, two registered read ports each
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem_a[wr_addr] <= wr_data;
        end
        if (b_we)
        begin
            mem_b[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            a_q0 <= mem_a[rd_addr0];
            a_q1 <= mem_a[rd_addr1];
            b_q0 <= mem_b[rd_addr0];
            b_q1 <= mem_b[rd_addr1];
        end
    end

    // emission toward the output register
    assign emit_final                  = ((e_reg + ONE) == cnt_reg);
    assign emit_chan.valid             = (state_reg == ST_EMIT_WR);
    assign emit_chan.data.sorted_value = rd_left;
    assign emit_chan.data.final_res    = emit_final;
    assign emit_chan.data.overflow     = drop_reg;

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= ZERO;
            drop_reg  <= 1'b0;
            width_reg <= ONE;
            lo_reg    <= ZERO;
            mid_reg   <= ZERO;
            hi_reg    <= ZERO;
            i_reg     <= ZERO;
            j_reg     <= ZERO;
            k_reg     <= ZERO;
            e_reg     <= ZERO;
            src_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    if (in_fire)
                    begin
                        cnt_reg <= cnt_after;
                        if (!has_room)
                        begin
                            drop_reg <= 1'b1;
                        end
                        if (in_chan.data.last)
                        begin
                            src_reg   <= 1'b0;
                            e_reg     <= ZERO;
                            width_reg <= ONE;
                            lo_reg    <= ZERO;
                            mid_reg   <= setup_mid;
                            hi_reg    <= setup_hi;
                            i_reg     <= ZERO;
                            j_reg     <= setup_mid;
                            k_reg     <= ZERO;
                            state_reg <= (cnt_after > ONE) ? ST_SORT_RD : ST_EMIT_RD;
                        end
                    end
                end
                ST_SORT_RD:
                begin
                    state_reg <= ST_SORT_WR;
                end
                ST_SORT_WR:
                begin
                    k_reg <= k_inc;
                    if (take_left)
                    begin
                        i_reg <= i_reg + ONE;
                    end
                    else
                    begin
                        j_reg <= j_reg + ONE;
                    end
                    state_reg <= ST_SORT_RD;
                    if (run_end)
                    begin
                        lo_reg  <= setup_lo;
                        mid_reg <= setup_mid;
                        hi_reg  <= setup_hi;
                        i_reg   <= setup_lo;
                        j_reg   <= setup_mid;
                        k_reg   <= setup_lo;
                        if (pass_end)
                        begin
                            width_reg <= w2;
                            src_reg   <= !src_reg;
                            if (sort_done)
                            begin
                                e_reg     <= ZERO;
                                state_reg <= ST_EMIT_RD;
                            end
                        end
                    end
                end
                ST_EMIT_RD:
                begin
                    state_reg <= ST_EMIT_WR;
                end
                ST_EMIT_WR:
                begin
                    if (emit_chan.ready)
                    begin
                        if (emit_final)
                        begin
                            cnt_reg   <= ZERO;
                            drop_reg  <= 1'b0;
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            e_reg     <= e_reg + ONE;
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // output register stage
    ms_out_reg u_out_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (emit_chan),
        .down  (out_chan)
    );

    // fill count never passes the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_N)
        else $error("fill count beyond store depth");

    // merge indices stay consistent within a run
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SORT_WR) |->
            ((k_reg < hi_reg) && (i_reg <= mid_reg) && (j_reg <= hi_reg)
             && ((i_reg + j_reg) == (k_reg + mid_reg))))
        else $error("merge index invariant broken");

    // the final transaction of a set reopens loading with an empty store
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_chan.valid && emit_chan.ready && emit_chan.data.final_res) |=>
            ((state_reg == ST_LOAD) && (cnt_reg == ZERO) && !drop_reg))
        else $error("set not closed after final transaction");

    // no loading while results are being emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        in_chan.ready |-> !emit_chan.valid)
        else $error("input open during emission");

endmodule

`default_nettype wire

FILE: src/ms_out_reg.sv
// single-entry output register that decouples the sorter from the consumer
`timescale 1ns / 1ps
`default_nettype none

module ms_out_reg (
    input  logic       clk,
    input  logic       rst_n,
    ms_stream_if.sink   up,
    ms_stream_if.source down
);

    logic                  full_reg;
    ms_pkg::out_item_t     data_reg;

    // take a new transaction when empty or when the held one leaves
    assign up.ready   = !full_reg || down.ready;
    assign down.valid = full_reg;
    assign down.data  = data_reg;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (up.ready)
        begin
            full_reg <= up.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (up.valid && up.ready)
        begin
            data_reg <= up.data;
        end
    end

endmodule

`default_nettype wire
